// ===== sv/sobel_edge_magnitude_3x3_macros.svh =====
// Assertion macros shared by the Sobel edge magnitude RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SEM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sem assertion failed");
// next-cycle implication
`define SEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sem assertion failed");
`else
`define SEM_ASSERT_IMPL(label, ante, cons)
`define SEM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/sem_pkg.sv =====
// Shared constants and controller/datapath types for the Sobel edge magnitude block.
// No dependencies.
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 8;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int GSUM_W     = 12;
    localparam int GRAD_W     = 9;
    localparam int SQ_W       = 18;

    localparam logic [PIX_W-1:0]      OUTSIDE      = 8'hFF;
    localparam logic [IMG_W_W-1:0]    WIDTH_RESET  = 11'd640;
    localparam logic [IMG_H_W-1:0]    HEIGHT_RESET = 12'd480;
    localparam logic [SQ_W-1:0]       ROOT_START   = 18'h1_0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic capture;
        logic calc;
        logic square;
        logic root_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic root_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== sv/sem_stream_if.sv =====
// Valid/ready stream interfaces for pixel beats in and result beats out.
// Depends on sem_pkg.
interface sem_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [sem_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface sem_result_if;
    logic                      valid;
    logic                      ready;
    logic [sem_pkg::PIX_W-1:0] edge_magnitude;
    logic                      frame_last;

    modport source (output valid, output edge_magnitude, output frame_last, input ready);
    modport sink   (input valid, input edge_magnitude, input frame_last, output ready);
endinterface

// ===== sv/sem_ctrl.sv =====
// Sequencer for one pixel: capture, window sums, squares, root iterations, hand-off.
// Depends on sem_pkg and the macros header.
`include "sobel_edge_magnitude_3x3_macros.svh"

module sem_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sem_pkg::t_dp_sts i_sts,
    output sem_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CALC   = 3'd1;
    localparam logic [2:0] S_SQUARE = 3'd2;
    localparam logic [2:0] S_ROOT   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_sts.root_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.load_out = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // root keeps iterating until the final bit position
    `SEM_ASSERT_NEXT(a_root_holds, (r_state == S_ROOT) && !i_sts.root_last, r_state == S_ROOT)
    // a finished pixel never waits once the output register is free
    `SEM_ASSERT_NEXT(a_done_leaves, (r_state == S_DONE) && i_sts.out_free, r_state == S_IDLE)

endmodule

// ===== sv/sem_dp.sv =====
// Datapath: config registers, raster counters, line memory, 3x3 window,
// gradient sums, squares, bit-serial square root and output register. Depends on sem_pkg.
`include "sobel_edge_magnitude_3x3_macros.svh"

module sem_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sem_pkg::t_dp_cmd               i_cmd,
    output sem_pkg::t_dp_sts               o_sts,
    input  logic [sem_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [sem_pkg::PIX_W-1:0]      o_edge_magnitude,
    output logic                           o_frame_last
);

    // config and raster position
    logic [sem_pkg::IMG_W_W-1:0] r_img_w;
    logic [sem_pkg::IMG_H_W-1:0] r_img_h;
    logic [sem_pkg::COL_W-1:0]   r_col_cnt;
    logic [sem_pkg::IMG_H_W-1:0] r_row_cnt;
    logic [sem_pkg::COL_W-1:0]   n_col_cnt;
    logic [sem_pkg::IMG_H_W-1:0] n_row_cnt;
    logic                        n_last;
    logic [sem_pkg::IMG_W_W-1:0] w_eff;
    logic [sem_pkg::IMG_H_W-1:0] h_eff;
    logic [sem_pkg::IMG_W_W-1:0] col_inc;
    logic [sem_pkg::IMG_H_W:0]   row_inc;

    // captured beat
    logic [sem_pkg::PIX_W-1:0]   r_pix;
    logic [sem_pkg::COL_W-1:0]   r_col;
    logic                        r_c1;
    logic                        r_c2;
    logic                        r_r1;
    logic                        r_r2;
    logic                        r_last;

    // line memory: [15:8] row r-2, [7:0] row r-1
    logic [2*sem_pkg::PIX_W-1:0] r_line_mem [sem_pkg::MAX_WIDTH];
    logic [2*sem_pkg::PIX_W-1:0] r_rd;

    // window: entries 0..2 column c-1, 3..5 column c-2, top to bottom
    logic [sem_pkg::PIX_W-1:0]   r_win [6];
    logic [sem_pkg::PIX_W-1:0]   p00, p01, p02, p10, p12, p20, p21, p22;

    logic signed [sem_pkg::GSUM_W-1:0] gx;
    logic signed [sem_pkg::GSUM_W-1:0] gy;
    logic signed [sem_pkg::GSUM_W-1:0] gx_sh;
    logic signed [sem_pkg::GSUM_W-1:0] gy_sh;
    logic signed [sem_pkg::GRAD_W-1:0] r_gx;
    logic signed [sem_pkg::GRAD_W-1:0] r_gy;
    logic signed [sem_pkg::SQ_W-1:0]   sq_x;
    logic signed [sem_pkg::SQ_W-1:0]   sq_y;

    // square root
    logic [sem_pkg::SQ_W-1:0] r_rem;
    logic [sem_pkg::SQ_W-1:0] r_root;
    logic [sem_pkg::SQ_W-1:0] r_bit;
    logic [sem_pkg::SQ_W-1:0] trial;

    logic                       r_out_valid;
    logic [sem_pkg::PIX_W-1:0]  r_out_mag;
    logic                       r_out_last;

    function automatic logic signed [sem_pkg::GSUM_W-1:0] ext(input logic [sem_pkg::PIX_W-1:0] v);
        ext = $signed({{(sem_pkg::GSUM_W-sem_pkg::PIX_W){1'b0}}, v});
    endfunction

    // clamp width to 1..MAX_WIDTH and height to at least 1
    always_comb begin
        if (r_img_w == '0) begin
            w_eff = sem_pkg::IMG_W_W'(1);
        end else if (r_img_w > sem_pkg::IMG_W_W'(sem_pkg::MAX_WIDTH)) begin
            w_eff = sem_pkg::IMG_W_W'(sem_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_img_w;
        end
        h_eff = (r_img_h == '0) ? sem_pkg::IMG_H_W'(1) : r_img_h;
    end

    // next raster position; counters left beyond a new limit wrap here too
    always_comb begin
        col_inc   = {1'b0, r_col_cnt} + sem_pkg::IMG_W_W'(1);
        row_inc   = {1'b0, r_row_cnt} + (sem_pkg::IMG_H_W+1)'(1);
        n_col_cnt = col_inc[sem_pkg::COL_W-1:0];
        n_row_cnt = r_row_cnt;
        n_last    = 1'b0;
        if (col_inc >= w_eff) begin
            n_col_cnt = '0;
            if (row_inc >= {1'b0, h_eff}) begin
                n_row_cnt = '0;
                n_last    = 1'b1;
            end else begin
                n_row_cnt = row_inc[sem_pkg::IMG_H_W-1:0];
            end
        end
    end

    // window with out-of-image substitution
    always_comb begin
        p02 = r_r2 ? r_rd[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W] : sem_pkg::OUTSIDE;
        p12 = r_r1 ? r_rd[sem_pkg::PIX_W-1:0] : sem_pkg::OUTSIDE;
        p22 = r_pix;
        p01 = r_c1 ? r_win[0] : sem_pkg::OUTSIDE;
        p21 = r_c1 ? r_win[2] : sem_pkg::OUTSIDE;
        p00 = r_c2 ? r_win[3] : sem_pkg::OUTSIDE;
        p10 = r_c2 ? r_win[4] : sem_pkg::OUTSIDE;
        p20 = r_c2 ? r_win[5] : sem_pkg::OUTSIDE;

        gx = (ext(p00) - ext(p02)) + ((ext(p10) - ext(p12)) <<< 1) + (ext(p20) - ext(p22));
        gy = (ext(p20) + (ext(p21) <<< 1) + ext(p22))
           - (ext(p00) + (ext(p01) <<< 1) + ext(p02));
        gx_sh = gx >>> 2;
        gy_sh = gy >>> 2;
    end

    assign sq_x  = r_gx * r_gx;
    assign sq_y  = r_gy * r_gy;
    assign trial = r_root + r_bit;

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w     <= sem_pkg::WIDTH_RESET;
            r_img_h     <= sem_pkg::HEIGHT_RESET;
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_win       <= '{default: sem_pkg::OUTSIDE};
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sem_pkg::CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[sem_pkg::IMG_W_W-1:0];
                    sem_pkg::CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[sem_pkg::IMG_H_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                r_col_cnt <= n_col_cnt;
                r_row_cnt <= n_row_cnt;
            end
            if (i_cmd.calc) begin
                r_win[3] <= r_win[0];
                r_win[4] <= r_win[1];
                r_win[5] <= r_win[2];
                r_win[0] <= p02;
                r_win[1] <= p12;
                r_win[2] <= p22;
            end
            if (i_cmd.square) begin
                r_bit <= sem_pkg::ROOT_START;
            end else if (i_cmd.root_step) begin
                r_bit <= r_bit >> 2;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix  <= i_pixel;
            r_col  <= r_col_cnt;
            r_c1   <= (r_col_cnt != '0);
            r_c2   <= (r_col_cnt >= sem_pkg::COL_W'(2));
            r_r1   <= (r_row_cnt != '0);
            r_r2   <= (r_row_cnt >= sem_pkg::IMG_H_W'(2));
            r_last <= n_last;
        end
        if (i_cmd.calc) begin
            r_gx <= gx_sh[sem_pkg::GRAD_W-1:0];
            r_gy <= gy_sh[sem_pkg::GRAD_W-1:0];
        end
        if (i_cmd.square) begin
            r_rem  <= $unsigned(sq_x) + $unsigned(sq_y);
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
        end
        if (i_cmd.load_out) begin
            r_out_mag  <= (r_root > sem_pkg::SQ_W'(255)) ? 8'hFF : r_root[sem_pkg::PIX_W-1:0];
            r_out_last <= r_last;
        end
    end

    // line memory: read on capture, written back in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_line_mem[r_col] <= {r_rd[sem_pkg::PIX_W-1:0], r_pix};
        end
        if (i_cmd.capture) begin
            r_rd <= r_line_mem[r_col_cnt];
        end
    end

    assign o_sts.root_last = r_bit[0];
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_edge_magnitude = r_out_mag;
    assign o_frame_last     = r_out_last;

    // root bit is a single position or spent
    `SEM_ASSERT_IMPL(a_bit_onehot, 1'b1, $onehot0(r_bit))
    // a pending result is never overwritten
    `SEM_ASSERT_IMPL(a_no_overwrite, i_cmd.load_out, !r_out_valid || i_out_ready)

endmodule

// ===== sv/sobel_edge_magnitude_3x3.sv =====
// Sobel edge magnitude over a 3x3 neighbourhood, streaming raster pixels.
// Depends on sem_pkg, sem_stream_if, sem_ctrl and sem_dp.
//
// Takes one 8-bit grey pixel per beat in raster order and returns one result beat per
// pixel: the Sobel magnitude of the 3x3 window whose bottom-right corner is that pixel.
// Gx and Gy are each floor-divided by 4, squared and summed, and the floor square root
// is saturated to 255. Pixels above the first row or left of the first column read as
// 255. frame_last flags the result of the final pixel of a frame. Width (register 0,
// clamped to 1..1024) and height (register 1, clamped to at least 1) are to be written
// by the user only while the block is idle; the block does not enforce this. Writes leave
// the raster counters alone; a counter at or past a new limit wraps at the next column
// wrap. Per pixel: capture with line-memory read, window sums with line-memory
// write-back, squaring, nine root iterations (one result bit each), then hand-off into
// the output register, which lets the next pixel be taken while a result beat still
// waits. Line memory holds no reset state; no clearing pass is needed after reset.
module sobel_edge_magnitude_3x3 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sem_pixel_if.sink                      i_pixel,
    sem_result_if.source                   o_result,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    sem_pkg::t_dp_cmd cmd;
    sem_pkg::t_dp_sts sts;
    logic             in_ready;

    // sequencer
    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pixel.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // arithmetic, storage and output register
    sem_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_pixel          (i_pixel.pixel_in),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_edge_magnitude (o_result.edge_magnitude),
        .o_frame_last     (o_result.frame_last)
    );

    assign i_pixel.ready = in_ready;

endmodule

// ===== tb/tb_sem_checker.sv =====
// Scoreboard for the Sobel edge magnitude block: watches both beat channels and the
// register port, predicts each result from its own copy of the raster state and compares.
// Depends on sem_pkg.
module tb_sem_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_pix_valid,
    input  logic                           i_pix_ready,
    input  logic [sem_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [sem_pkg::PIX_W-1:0]      i_edge_magnitude,
    input  logic                           i_frame_last,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [sem_pkg::PIX_W-1:0] magnitude;
        logic                      last;
    } t_edge_result;

    logic [sem_pkg::IMG_W_W-1:0] width_reg;
    logic [sem_pkg::IMG_H_W-1:0] height_reg;
    logic [sem_pkg::PIX_W-1:0]   row_older [sem_pkg::MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0]   row_newer [sem_pkg::MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0]   win_cols [6];
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    t_edge_result                edge_expected_q [$];
    int                          fail_count = 0;

    // Sobel magnitude of the window ending at px, then shift the window and rows along.
    function automatic t_edge_result sobel_predict(input logic [sem_pkg::PIX_W-1:0] px);
        int unsigned  eff_w;
        int unsigned  eff_h;
        int unsigned  idx;
        int           nb [3][3];
        int           gx;
        int           gy;
        int           sum_sq;
        int           root;
        int           b;
        t_edge_result res;
        eff_w = (width_reg == 0) ? 1
              : ((width_reg > sem_pkg::MAX_WIDTH) ? sem_pkg::MAX_WIDTH : width_reg);
        eff_h = (height_reg == 0) ? 1 : height_reg;
        idx   = col_pos % sem_pkg::MAX_WIDTH;

        nb[0][2] = (row_pos >= 2) ? int'(row_older[idx]) : int'(sem_pkg::OUTSIDE);
        nb[1][2] = (row_pos >= 1) ? int'(row_newer[idx]) : int'(sem_pkg::OUTSIDE);
        nb[2][2] = int'(px);
        for (int i = 0; i < 3; i++) begin
            nb[i][1] = (col_pos >= 1) ? int'(win_cols[i])     : int'(sem_pkg::OUTSIDE);
            nb[i][0] = (col_pos >= 2) ? int'(win_cols[3 + i]) : int'(sem_pkg::OUTSIDE);
        end

        gx = (nb[0][0] - nb[0][2]) + 2 * (nb[1][0] - nb[1][2]) + (nb[2][0] - nb[2][2]);
        gy = (nb[2][0] + 2 * nb[2][1] + nb[2][2]) - (nb[0][0] + 2 * nb[0][1] + nb[0][2]);
        gx = gx >>> 2;
        gy = gy >>> 2;
        sum_sq = gx * gx + gy * gy;

        // floor root, one bit at a time from the top
        root = 0;
        for (b = 9; b >= 0; b--) begin
            if ((root + (1 << b)) * (root + (1 << b)) <= sum_sq)
                root += (1 << b);
        end
        res.magnitude = (root > 255) ? 8'hFF : sem_pkg::PIX_W'(root);

        for (int i = 0; i < 3; i++) begin
            win_cols[3 + i] = win_cols[i];
            win_cols[i]     = sem_pkg::PIX_W'(nb[i][2]);
        end
        row_older[idx] = row_newer[idx];
        row_newer[idx] = px;

        // counters may sit past a freshly narrowed limit: wrap after this pixel
        res.last = 1'b0;
        if (col_pos + 1 >= eff_w) begin
            col_pos = 0;
            if (row_pos + 1 >= eff_h) begin
                row_pos  = 0;
                res.last = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_edge_result want;
        if (!i_rst_n) begin
            width_reg  = sem_pkg::WIDTH_RESET;
            height_reg = sem_pkg::HEIGHT_RESET;
            for (int i = 0; i < 6; i++)
                win_cols[i] = sem_pkg::OUTSIDE;
            col_pos = 0;
            row_pos = 0;
            edge_expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sem_pkg::CFG_IMAGE_WIDTH:
                        width_reg  = i_cfg_data[sem_pkg::IMG_W_W-1:0];
                    sem_pkg::CFG_IMAGE_HEIGHT:
                        height_reg = i_cfg_data[sem_pkg::IMG_H_W-1:0];
                    default: ;
                endcase
            end
            // results first: a beat leaving now belongs to an older pixel
            if (i_res_valid && i_res_ready) begin
                if (edge_expected_q.size() == 0) begin
                    $error({"result beat with no pixel outstanding: ",
                            "edge_magnitude %0d frame_last %0b"},
                           i_edge_magnitude, i_frame_last);
                    fail_count++;
                end else begin
                    want = edge_expected_q.pop_front();
                    if (i_edge_magnitude !== want.magnitude) begin
                        $error("edge_magnitude mismatch: expected %0d, got %0d",
                               want.magnitude, i_edge_magnitude);
                        fail_count++;
                    end
                    if (i_frame_last !== want.last) begin
                        $error("frame_last mismatch: expected %0b, got %0b",
                               want.last, i_frame_last);
                        fail_count++;
                    end
                end
            end
            if (i_pix_valid && i_pix_ready)
                edge_expected_q.push_back(sobel_predict(i_pixel));
        end
        o_fail_count = fail_count;
        o_pending    = edge_expected_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the Sobel edge magnitude testbench: clock, reset, pixel beats, register writes,
// result back-pressure and the verdict. Depends on sem_pkg, sem_stream_if, the block
// and tb_sem_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS = 2000;
    localparam int BIG_AFTER     = 600;      // wide-row frame goes in once this many are sent
    localparam int RUN_LIMIT     = 1_000_000;
    localparam int CALM_FROM     = 12000;    // no idling on either side in this window
    localparam int CALM_TO       = 20000;
    localparam int HOLD_AT       = 4000;     // result side holds off here
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;

    // 3x3 frame with 255 on the left and along the bottom: both gradients large, so the
    // magnitude at the last pixel runs past 255 and must saturate
    localparam logic [sem_pkg::PIX_W-1:0] SATURATING_FRAME [9] = '{
        8'hFF, 8'h00, 8'h00,
        8'hFF, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'h00
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sem_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             cycle_count = 0;
    int                             fail_count;
    int                             pending_count;

    // stimulus side view of the raster, used only to plan register writes safely
    logic [sem_pkg::IMG_W_W-1:0]    width_reg;
    logic [sem_pkg::IMG_H_W-1:0]    height_reg;
    int unsigned                    raster_col;
    int unsigned                    raster_row;
    int unsigned                    pixel_count;
    bit                             held = 1'b0;

    sem_pixel_if  pix_if ();
    sem_result_if res_if ();

    sobel_edge_magnitude_3x3 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pixel     (pix_if),
        .o_result    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tb_sem_checker sobel_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pix_valid      (pix_if.valid),
        .i_pix_ready      (pix_if.ready),
        .i_pixel          (pix_if.pixel_in),
        .i_res_valid      (res_if.valid),
        .i_res_ready      (res_if.ready),
        .i_edge_magnitude (res_if.edge_magnitude),
        .i_frame_last     (res_if.frame_last),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // watchdog: a hung handshake or a lost result ends up here
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit calm();
        return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
    endfunction

    function automatic int unsigned active_width();
        return (width_reg == 0) ? 1
             : ((width_reg > sem_pkg::MAX_WIDTH) ? sem_pkg::MAX_WIDTH : width_reg);
    endfunction

    function automatic int unsigned active_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // mostly uniform grey levels, with the two extremes weighted up
    function automatic logic [sem_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return sem_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Result side: random back-pressure, one long hold-off so the block fills and stalls
    // its pixel input, and none at all inside the calm window.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && cycle_count >= HOLD_AT) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                held = 1'b1;
            end else if (calm()) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // One pixel beat. Called at a falling edge, returns at the falling edge after the
    // beat was taken; valid stays high into the next call unless a gap is drawn.
    task automatic send_pixel(input logic [sem_pkg::PIX_W-1:0] px);
        while (!calm() && $urandom_range(0, 99) < 25) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.pixel_in <= px;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        pixel_count++;
        // same wrap rule as the block, including counters left past a new limit
        if (raster_col + 1 >= active_width()) begin
            raster_col = 0;
            raster_row = (raster_row + 1 >= active_height()) ? 0 : raster_row + 1;
        end else begin
            raster_col++;
        end
    endtask

    // Stop offering and wait until every result beat is back: the block is then idle.
    task automatic settle();
        pix_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
    endtask

    // Register write, only ever issued while the block is idle.
    task automatic write_register(input logic [sem_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sem_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == sem_pkg::CFG_IMAGE_WIDTH)
            width_reg = data[sem_pkg::IMG_W_W-1:0];
        else
            height_reg = data[sem_pkg::IMG_H_W-1:0];
    endtask

    // Random pixels up to the end of the current frame (a whole frame from row 0, col 0).
    task automatic finish_frame();
        do
            send_pixel(random_pixel());
        while (raster_col != 0 || raster_row != 0);
    endtask

    // Widest rows: width register written with every data bit set (masks to 2047, clamps
    // to 1024), a full row plus a few, a same-size rewrite at 1024, then both limits
    // pulled to 3 under the column, which wraps early; row 2 then ends the frame.
    task automatic wide_row_frame();
        write_register(sem_pkg::CFG_IMAGE_WIDTH, 12'hFFF);
        write_register(sem_pkg::CFG_IMAGE_HEIGHT, 12'd4095);
        repeat (sem_pkg::MAX_WIDTH + 6) send_pixel(random_pixel());
        settle();
        write_register(sem_pkg::CFG_IMAGE_WIDTH, 12'd1024);
        repeat (4) send_pixel(random_pixel());
        settle();
        write_register(sem_pkg::CFG_IMAGE_WIDTH, 12'd3);
        write_register(sem_pkg::CFG_IMAGE_HEIGHT, 12'd3);
        finish_frame();
        settle();
    endtask

    initial begin
        int unsigned new_w;
        int unsigned new_h;
        int unsigned frame_len;
        int unsigned split;
        int unsigned random_end;
        bit          big_done;
        i_rst_n         = 1'b0;
        pix_if.valid    = 1'b0;
        pix_if.pixel_in = '0;
        cfg_we          = 1'b0;
        cfg_index       = sem_pkg::CFG_IMAGE_WIDTH;
        cfg_data        = '0;
        width_reg       = sem_pkg::WIDTH_RESET;
        height_reg      = sem_pkg::HEIGHT_RESET;
        raster_col      = 0;
        raster_row      = 0;
        pixel_count     = 0;
        big_done        = 1'b0;

        // synchronous reset
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed ---
        // Reset geometry (640 x 480): a few beats along the top row, with the left and
        // top borders in play and every pixel bit toggling.
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h55);
        send_pixel(8'hAA);
        settle();
        // Shrink to 3 x 3 with the column already past the new width: it wraps after
        // the next pixel, then rows 1 and 2 run out to frame_last.
        write_register(sem_pkg::CFG_IMAGE_WIDTH, 12'd3);
        write_register(sem_pkg::CFG_IMAGE_HEIGHT, 12'd3);
        finish_frame();
        // magnitude saturation
        foreach (SATURATING_FRAME[i])
            send_pixel(SATURATING_FRAME[i]);
        settle();

        // --- random ---
        // Whole frames of random size; widening only at a frame boundary so no line
        // memory entry is read before it has been written. Mid-frame, only the height
        // may move either way and the width may only narrow.
        random_end = pixel_count + RANDOM_PIXELS;
        while (pixel_count < random_end) begin
            if (!big_done && pixel_count >= BIG_AFTER) begin
                wide_row_frame();
                big_done = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0:       new_w = $urandom_range(0, 2);
                    1:       new_w = $urandom_range(17, 40);
                    default: new_w = $urandom_range(3, 16);
                endcase
                case ($urandom_range(0, 19))
                    0, 1, 2: new_h = $urandom_range(0, 2);
                    3, 4, 5: new_h = $urandom_range(7, 12);
                    default: new_h = $urandom_range(3, 6);
                endcase
                write_register(sem_pkg::CFG_IMAGE_WIDTH, sem_pkg::CFG_DATA_W'(new_w));
                write_register(sem_pkg::CFG_IMAGE_HEIGHT, sem_pkg::CFG_DATA_W'(new_h));
                repeat ($urandom_range(1, 3)) begin
                    frame_len = active_width() * active_height();
                    if (frame_len > 1 && $urandom_range(0, 3) == 0) begin
                        split = $urandom_range(1, frame_len - 1);
                        repeat (split) send_pixel(random_pixel());
                        settle();
                        if ($urandom_range(0, 1))
                            write_register(sem_pkg::CFG_IMAGE_HEIGHT,
                                sem_pkg::CFG_DATA_W'($urandom_range(0, 12)));
                        if ($urandom_range(0, 1))
                            write_register(sem_pkg::CFG_IMAGE_WIDTH,
                                sem_pkg::CFG_DATA_W'($urandom_range(0, active_width())));
                    end
                    finish_frame();
                end
                settle();
            end
        end

        // --- end of run ---
        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
